// File: hdl/char_lcd_refresh_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD refresh engine
// Same-cycle and next-cycle implication checks with a reset guard.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_REFRESH_ENGINE_MACROS_SVH
`define CHAR_LCD_REFRESH_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCDRE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCDRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/lcdre_pkg.sv
// ----------------------------------------------------------------------------
// lcdre_pkg
// Shared types, codes and constants of the character LCD refresh engine.
// ----------------------------------------------------------------------------
package lcdre_pkg;

   localparam int COLUMNS_DEF = 16;
   localparam int ROWS_DEF    = 2;

   localparam logic [7:0] HOME_CMD = 8'h80;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_POS   = 2'd1,
      OP_TICK  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HOME = 2'd1,
      PH_LINE = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic [4:0] column;
      logic [2:0] row;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] lcd_byte;
      logic       is_data;
   } result_type;

   // Set-address command for the start of a display line.
   function automatic logic [7:0] line_cmd(input logic [2:0] line);
      logic [7:0] cmd;
      case (line)
         3'd0:    cmd = HOME_CMD + 8'h00;
         3'd1:    cmd = HOME_CMD + 8'h40;
         3'd2:    cmd = HOME_CMD + 8'h14;
         3'd3:    cmd = HOME_CMD + 8'h54;
         default: cmd = HOME_CMD;
      endcase
      return cmd;
   endfunction

endpackage

// File: hdl/lcdre_ram.sv
// ----------------------------------------------------------------------------
// lcdre_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lcdre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lcdre_core.sv
// ----------------------------------------------------------------------------
// lcdre_core
// Frame buffer, write cursor and refresh sequencer; handles one item per cycle while adv is high.
// ----------------------------------------------------------------------------
`include "char_lcd_refresh_engine_macros.svh"

module lcdre_core #(
   parameter int COLUMNS = lcdre_pkg::COLUMNS_DEF,
   parameter int ROWS    = lcdre_pkg::ROWS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  lcdre_pkg::item_type    item,
   output lcdre_pkg::result_type  res
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SW    = $clog2(CELLS + 1);
   localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int LW    = $clog2(ROWS + 1);

   lcdre_pkg::phase_type phase_ff, phase_in;
   logic                 pending_ff, pending_in;
   logic [AW-1:0]        cursor_ff, cursor_in;
   logic [SW-1:0]        scan_ff, scan_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [LW-1:0]        line_ff, line_in;
   logic [CELLS-1:0]     valid_ff, valid_in;
   logic                 byp_ff, byp_in;
   logic [7:0]           byp_data_ff;
   logic                 vld_rd_ff;

   logic                 we;
   logic [AW-1:0]        waddr;
   logic [AW-1:0]        raddr;
   logic [7:0]           ram_rdata;
   logic [7:0]           cell_byte;
   logic [AW-1:0]        pos_addr;
   logic                 pos_ok;

   assign pos_ok   = (32'(item.column) < COLUMNS) && (32'(item.row) < ROWS);
   assign pos_addr = AW'(32'(item.column) + 32'(item.row) * COLUMNS);
   assign waddr    = cursor_ff;

   // The read address follows the next scan position so that the cell is
   // ready when the data step comes; a write to that cell is forwarded.
   assign raddr = (32'(scan_in) < CELLS) ? AW'(scan_in) : '0;

   assign cell_byte = byp_ff ? byp_data_ff : (vld_rd_ff ? ram_rdata : 8'h00);

   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      cursor_in  = cursor_ff;
      scan_in    = scan_ff;
      col_in     = col_ff;
      line_in    = line_ff;
      valid_in   = valid_ff;
      we         = 1'b0;
      res        = '0;
      if (adv) begin
         case (item.opcode)
            lcdre_pkg::OP_WRITE: begin
               we              = 1'b1;
               valid_in[waddr] = 1'b1;
               pending_in      = 1'b1;
               cursor_in       = (cursor_ff == AW'(CELLS - 1)) ? '0 : cursor_ff + AW'(1);
            end
            lcdre_pkg::OP_POS: begin
               if (pos_ok) begin
                  cursor_in = pos_addr;
               end
            end
            lcdre_pkg::OP_TICK: begin
               case (phase_ff)
                  lcdre_pkg::PH_IDLE: begin
                     if (pending_ff) begin
                        pending_in = 1'b0;
                        phase_in   = lcdre_pkg::PH_HOME;
                     end
                  end
                  lcdre_pkg::PH_HOME: begin
                     scan_in      = '0;
                     col_in       = '0;
                     line_in      = '0;
                     phase_in     = lcdre_pkg::PH_LINE;
                     res.valid    = 1'b1;
                     res.lcd_byte = lcdre_pkg::HOME_CMD;
                  end
                  lcdre_pkg::PH_LINE: begin
                     phase_in = lcdre_pkg::PH_DATA;
                     if (col_ff == '0) begin
                        res.valid    = 1'b1;
                        res.lcd_byte = lcdre_pkg::line_cmd(3'(line_ff));
                     end
                  end
                  default: begin
                     res.valid    = 1'b1;
                     res.lcd_byte = cell_byte;
                     res.is_data  = 1'b1;
                     scan_in      = scan_ff + SW'(1);
                     if (col_ff == CW'(COLUMNS - 1)) begin
                        col_in  = '0;
                        line_in = line_ff + LW'(1);
                     end else begin
                        col_in = col_ff + CW'(1);
                     end
                     phase_in = (scan_ff == SW'(CELLS - 1)) ? lcdre_pkg::PH_IDLE
                                                            : lcdre_pkg::PH_LINE;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   assign byp_in = we && (waddr == raddr);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lcdre_pkg::PH_IDLE;
         pending_ff <= 1'b0;
         cursor_ff  <= '0;
         scan_ff    <= '0;
         col_ff     <= '0;
         line_ff    <= '0;
         valid_ff   <= '0;
         byp_ff     <= 1'b0;
         vld_rd_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         cursor_ff  <= cursor_in;
         scan_ff    <= scan_in;
         col_ff     <= col_in;
         line_ff    <= line_in;
         valid_ff   <= valid_in;
         byp_ff     <= byp_in;
         vld_rd_ff  <= valid_ff[raddr];
      end
      byp_data_ff <= item.char_code;
   end

   lcdre_ram #(
      .WIDTH (8),
      .DEPTH (CELLS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (item.char_code),
      .rd_addr (raddr),
      .rd_data (ram_rdata)
   );

   `LCDRE_ASSERT_NOW(a_res_from_tick, clock, reset, res.valid, adv && (item.opcode == lcdre_pkg::OP_TICK) && (phase_ff != lcdre_pkg::PH_IDLE), "result without a busy refresh tick")
   `LCDRE_ASSERT_NOW(a_cursor_range, clock, reset, 1'b1, 32'(cursor_ff) < CELLS, "write cursor beyond the frame buffer")
   `LCDRE_ASSERT_NOW(a_scan_range, clock, reset, phase_ff == lcdre_pkg::PH_DATA, 32'(scan_ff) < CELLS, "data step beyond the last cell")
   `LCDRE_ASSERT_NEXT(a_home_restart, clock, reset, adv && (item.opcode == lcdre_pkg::OP_TICK) && (phase_ff == lcdre_pkg::PH_HOME), (phase_ff == lcdre_pkg::PH_LINE) && (scan_ff == '0) && (col_ff == '0), "home step did not restart the scan")

endmodule

// File: hdl/char_lcd_refresh_engine.sv
// ----------------------------------------------------------------------------
// char_lcd_refresh_engine
// Character LCD frame buffer with a refresh sequencer, stream interfaces.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tuser: opcode[1:0]; tdata: char_code[7:0], column[12:8], row[15:13]
//  rsp_    | out       | tuser: is_data[0]; tdata: lcd_byte[7:0]
//
//  One item per cycle while no result is stalled: an item is held in the input
//  register, is handled there, and its result (if any) appears in the output
//  register on the next edge. The result passes the input and then the result
//  register; the frame buffer is read ahead of the data step and adds no delay.
//  Reset is synchronous; it empties both registers and clears the frame buffer
//  at once through per-cell valid bits. A stalled result holds the input stage.
// ----------------------------------------------------------------------------
module char_lcd_refresh_engine #(
   parameter int COLUMNS = lcdre_pkg::COLUMNS_DEF,
   parameter int ROWS    = lcdre_pkg::ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // char_code[7:0], column[12:8], row[15:13]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // lcd_byte[7:0]
   output logic [0:0]  rsp_tuser    // is_data[0]
);

   logic                  s1_valid_ff;
   lcdre_pkg::item_type   s1_item_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_byte_ff;
   logic                  rsp_is_data_ff;
   logic                  adv;
   logic                  req_take;
   lcdre_pkg::result_type res;

   // The held item is handled whenever the result register can take its result.
   assign adv        = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!s1_valid_ff || adv);
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (adv) begin
            rsp_valid_ff <= res.valid;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         s1_item_ff.opcode    <= req_tuser;
         s1_item_ff.char_code <= req_tdata[7:0];
         s1_item_ff.column    <= req_tdata[12:8];
         s1_item_ff.row       <= req_tdata[15:13];
      end
      if (adv) begin
         rsp_byte_ff    <= res.lcd_byte;
         rsp_is_data_ff <= res.is_data;
      end
   end

   lcdre_core #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .item  (s1_item_ff),
      .res   (res)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_byte_ff;
   assign rsp_tuser[0] = rsp_is_data_ff;

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Character LCD refresh engine testbench
// Drives write, cursor, tick and unused-opcode items into the engine. A scoreboard keeps its
// own copy of the frame buffer and sequencer, predicts the display bytes that
// each tick sends, and checks them in order against the result stream.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          COLUMNS   = lcdre_pkg::COLUMNS_DEF;
   localparam int          ROWS      = lcdre_pkg::ROWS_DEF;
   localparam int          CELLS     = COLUMNS * ROWS;
   localparam logic [1:0]  OP_UNUSED = 2'd3;
   localparam int          RUN_ITEMS = 1400;
   localparam int          CYCLE_CAP = 200000;

   typedef struct {
      logic [7:0] lcd_byte;
      logic       is_data;
   } bus_byte_type;

   class lcd_bus_scoreboard;
      logic [7:0]           cells [CELLS];
      int unsigned          cursor;
      int unsigned          scan;
      bit                   refresh_due;
      lcdre_pkg::phase_type phase;
      bus_byte_type         bus_bytes_due [$];
      int                   failures;

      function new();
         foreach (cells[i]) cells[i] = 8'h00;
         cursor      = 0;
         scan        = 0;
         refresh_due = 1'b0;
         phase       = lcdre_pkg::PH_IDLE;
         failures    = 0;
      endfunction

      function void push_byte(logic [7:0] b, logic d);
         bus_byte_type e;
         e.lcd_byte = b;
         e.is_data  = d;
         bus_bytes_due.push_back(e);
      endfunction

      // Advances the shadow engine by one accepted item.
      function void note_request(logic [1:0] op, logic [7:0] ch, logic [4:0] col,
                                 logic [2:0] row);
         logic [7:0] line_offset [4];
         line_offset = '{8'h00, 8'h40, 8'h14, 8'h54};
         case (op)
            lcdre_pkg::OP_WRITE: begin
               cells[cursor] = ch;
               cursor        = (cursor + 1) % CELLS;
               refresh_due   = 1'b1;
            end
            lcdre_pkg::OP_POS: begin
               if (col < COLUMNS && row < ROWS) cursor = col + row * COLUMNS;
            end
            lcdre_pkg::OP_TICK: begin
               case (phase)
                  lcdre_pkg::PH_IDLE: begin
                     if (refresh_due) begin
                        refresh_due = 1'b0;
                        phase       = lcdre_pkg::PH_HOME;
                     end
                  end
                  lcdre_pkg::PH_HOME: begin
                     scan  = 0;
                     phase = lcdre_pkg::PH_LINE;
                     push_byte(lcdre_pkg::HOME_CMD, 1'b0);
                  end
                  lcdre_pkg::PH_LINE: begin
                     phase = lcdre_pkg::PH_DATA;
                     // Only a cell at the start of a display line gets an address.
                     if (scan % COLUMNS == 0)
                        push_byte(lcdre_pkg::HOME_CMD + line_offset[scan / COLUMNS], 1'b0);
                  end
                  default: begin
                     push_byte(cells[scan], 1'b1);
                     scan  = scan + 1;
                     phase = (scan >= CELLS) ? lcdre_pkg::PH_IDLE : lcdre_pkg::PH_LINE;
                  end
               endcase
            end
            default: ;
         endcase
      endfunction

      function void check_bus_byte(logic [7:0] b, logic d);
         bus_byte_type e;
         if (bus_bytes_due.size() == 0) begin
            $error("unexpected item: lcd_byte %h is_data %b", b, d);
            failures++;
            return;
         end
         e = bus_bytes_due.pop_front();
         if (b !== e.lcd_byte) begin
            $error("lcd_byte: expected %h, got %h", e.lcd_byte, b);
            failures++;
         end
         if (d !== e.is_data) begin
            $error("is_data: expected %b, got %b", e.is_data, d);
            failures++;
         end
      endfunction

      function int waiting();
         return bus_bytes_due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // char_code[7:0], column[12:8], row[15:13]
   logic [1:0]  req_tuser;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // lcd_byte[7:0]
   logic [0:0]  rsp_tuser;   // is_data[0]

   lcd_bus_scoreboard sb = new();
   bit                steady = 1'b0;
   int                cycles = 0;
   int                counted = 0;

   char_lcd_refresh_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Monitor for both channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_bus_byte(rsp_tdata, rsp_tuser[0]);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[7:0], req_tdata[12:8], req_tdata[15:13]);
      end
   end

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= (steady || $urandom_range(99) >= 12);
      end
   end

   task automatic send(input logic [1:0] op, input logic [7:0] ch, input logic [4:0] col,
                       input logic [2:0] row);
      while (!steady && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {row, col, ch};
      do @(posedge clock); while (!req_tready);
      if (!(op == OP_UNUSED || (op == lcdre_pkg::OP_POS && (col >= COLUMNS || row >= ROWS))))
         counted++;
   endtask

   task automatic send_tick();
      send(lcdre_pkg::OP_TICK, 8'($urandom_range(255)), 5'($urandom_range(31)),
           3'($urandom_range(7)));
   endtask

   // Any opcode, any field value; most positions land out of range.
   task automatic send_noise();
      send(2'($urandom_range(3)), 8'($urandom_range(255)), 5'($urandom_range(31)),
           3'($urandom_range(7)));
   endtask

   task automatic drain();
      while (sb.waiting() != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= lcdre_pkg::OP_WRITE;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: field extremes, cursor wrap, ignored positions and the
      // start of a refresh with a write landing in the middle of it.
      send(lcdre_pkg::OP_WRITE, 8'h00, 5'd0, 3'd0);
      send(lcdre_pkg::OP_WRITE, 8'hFF, 5'd31, 3'd7);
      send(lcdre_pkg::OP_POS, 8'hFF, 5'(COLUMNS - 1), 3'(ROWS - 1));
      send(lcdre_pkg::OP_WRITE, 8'hA5, 5'd0, 3'd0);
      send(lcdre_pkg::OP_WRITE, 8'h5A, 5'd0, 3'd0);
      send(lcdre_pkg::OP_POS, 8'h00, 5'(COLUMNS), 3'd0);
      send(lcdre_pkg::OP_POS, 8'h00, 5'd0, 3'(ROWS));
      send(lcdre_pkg::OP_POS, 8'h00, 5'd31, 3'd7);
      send(OP_UNUSED, 8'hFF, 5'd31, 3'd7);
      send(lcdre_pkg::OP_POS, 8'h00, 5'd0, 3'd1);
      send(lcdre_pkg::OP_WRITE, 8'h7E, 5'd0, 3'd0);
      repeat (6) send_tick();
      send(lcdre_pkg::OP_WRITE, 8'h81, 5'd0, 3'd0);
      send(lcdre_pkg::OP_POS, 8'h00, 5'd3, 3'd0);
      repeat (6) send_tick();
      req_tvalid <= 1'b0;
      drain();

      // Random part: mostly fills followed by runs of ticks with occasional noise
      // items, mixed with stretches of arbitrary items.
      counted = 0;
      while (counted < RUN_ITEMS) begin
         steady = (counted >= 500 && counted < 800);
         if ($urandom_range(99) < 75) begin
            if ($urandom_range(1))
               send(lcdre_pkg::OP_POS, 8'($urandom_range(255)),
                    5'($urandom_range(COLUMNS - 1)), 3'($urandom_range(ROWS - 1)));
            n = $urandom_range(8, 1);
            repeat (n) send(lcdre_pkg::OP_WRITE, 8'($urandom_range(255)),
                            5'($urandom_range(31)), 3'($urandom_range(7)));
            n = $urandom_range(2 * CELLS + 12, 2 * CELLS);
            repeat (n) begin
               if ($urandom_range(99) < 8) send_noise();
               else send_tick();
            end
         end else begin
            repeat ($urandom_range(20, 5)) send_noise();
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;
      drain();
      repeat (8) @(posedge clock);

      if (sb.failures == 0 && sb.waiting() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/lcdre_pkg.sv
hdl/lcdre_ram.sv
hdl/lcdre_core.sv
hdl/char_lcd_refresh_engine.sv
test/testbench.sv
